### hw/rtl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants of the defrost cycle controller
// Item and result structs, phase codes, register indexes and time limits.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int unsigned TIME_W   = 13;
  localparam int unsigned MINUTE_W = 10;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned DIFF_W   = 15;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = 13'd8191;

  // phase codes
  localparam logic [PHASE_W-1:0] PHASE_WORK        = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_PUMP_DOWN   = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_DEFROST     = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_DRYING      = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_COIL_FREEZE = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_WORK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_DOWN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFROST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRYING      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COIL_FREEZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SET_POINT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFERENTIAL = 3'd6;

  typedef struct packed {
    logic                     minute_elapsed;
    logic                     emergency_request;
    logic signed [TEMP_W-1:0] temperature;
  } dcc_in_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               pump_on;
    logic               drain_tray_on;
    logic               coil_heater_on;
    logic               fan_on;
  } dcc_out_t;

endpackage

### hw/rtl/defrost_cycle_controller_unit.sv
// ----------------------------------------------------------------------------
// defrost_cycle_controller_unit
// Defrost phase sequencer with minute counter, emergency shift and thermostat.
// ----------------------------------------------------------------------------
// path: an item passes the input register, then the result register; one compare
//   chain sits between the two, and a low out_ready can hold the item in between
// throughput: one item per cycle while the output is not stalled by out_ready
// reset: rst clears the pipeline valids, cycle state and loads register defaults
module defrost_cycle_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dcc_pkg::dcc_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dcc_pkg::dcc_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned TW = dcc_pkg::TIME_W;
  localparam int unsigned MW = dcc_pkg::MINUTE_W;
  localparam int unsigned SW = TW + 2;

  // configuration registers
  logic [MW-1:0]                     pump_work_minutes;
  logic [MW-1:0]                     pump_down_minutes;
  logic [MW-1:0]                     defrost_minutes;
  logic [MW-1:0]                     drying_minutes;
  logic [MW-1:0]                     coil_freeze_minutes;
  logic signed [dcc_pkg::TEMP_W-1:0] set_point;
  logic [dcc_pkg::DIFF_W-1:0]        differential;

  // cycle state
  logic [TW-1:0] cycle_minutes, cycle_minutes_next;
  logic [TW-1:0] emergency_offset, emergency_offset_next;
  logic          emergency_active, emergency_active_next;
  logic          emergency_latched, emergency_latched_next;
  logic          reached_low_band, reached_low_band_next;

  // pipeline
  logic              in_reg_valid;
  dcc_pkg::dcc_in_t  in_reg;
  logic              advance;
  dcc_pkg::dcc_out_t result_next;

  assign cfg_ready = 1'b1;
  assign advance   = in_reg_valid && (!out_valid || out_ready);
  assign in_ready  = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_work_minutes   <= 10'd2;
      pump_down_minutes   <= 10'd2;
      defrost_minutes     <= 10'd4;
      drying_minutes      <= 10'd4;
      coil_freeze_minutes <= 10'd2;
      set_point           <= '0;
      differential        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dcc_pkg::REG_PUMP_WORK:    pump_work_minutes   <= cfg_data[MW-1:0];
        dcc_pkg::REG_PUMP_DOWN:    pump_down_minutes   <= cfg_data[MW-1:0];
        dcc_pkg::REG_DEFROST:      defrost_minutes     <= cfg_data[MW-1:0];
        dcc_pkg::REG_DRYING:       drying_minutes      <= cfg_data[MW-1:0];
        dcc_pkg::REG_COIL_FREEZE:  coil_freeze_minutes <= cfg_data[MW-1:0];
        dcc_pkg::REG_SET_POINT:    set_point           <= $signed(cfg_data);
        dcc_pkg::REG_DIFFERENTIAL: differential        <= cfg_data[dcc_pkg::DIFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  // evaluation of the item held in the input register
  logic [TW-1:0]          minutes_ticked;
  logic                   emergency;
  logic signed [SW-1:0]   shifted;
  logic [TW-1:0]          shifted_sat;
  logic [TW-1:0]          time_used;
  logic [TW-1:0]          end1, end2, end3, end4, end5;
  logic [dcc_pkg::PHASE_W-1:0] phase;
  logic signed [dcc_pkg::TEMP_W:0] low_band;

  always_comb begin
    minutes_ticked = cycle_minutes;
    if (in_reg.minute_elapsed && cycle_minutes != dcc_pkg::TIME_MAX) begin
      minutes_ticked = cycle_minutes + 1'b1;
    end

    emergency_offset_next = emergency_offset;
    if (in_reg.emergency_request && !emergency_active &&
        minutes_ticked < TW'(pump_work_minutes)) begin
      emergency_offset_next = minutes_ticked;
    end

    emergency = in_reg.emergency_request || emergency_latched;
    shifted = $signed(SW'(minutes_ticked)) + $signed(SW'(pump_work_minutes))
              - $signed(SW'(emergency_offset_next));
    if (shifted < 0) begin
      shifted_sat = '0;
    end else if (shifted > $signed(SW'(dcc_pkg::TIME_MAX))) begin
      shifted_sat = dcc_pkg::TIME_MAX;
    end else begin
      shifted_sat = shifted[TW-1:0];
    end
    time_used = emergency ? shifted_sat : minutes_ticked;

    end1 = TW'(pump_work_minutes);
    end2 = end1 + TW'(pump_down_minutes);
    end3 = end2 + TW'(defrost_minutes);
    end4 = end3 + TW'(drying_minutes);
    end5 = end4 + TW'(coil_freeze_minutes);

    cycle_minutes_next     = minutes_ticked;
    emergency_active_next  = emergency;
    emergency_latched_next = emergency;
    if (time_used < end1) begin
      phase = dcc_pkg::PHASE_WORK;
    end else if (time_used < end2) begin
      phase = dcc_pkg::PHASE_PUMP_DOWN;
    end else if (time_used < end3) begin
      phase = dcc_pkg::PHASE_DEFROST;
    end else if (time_used < end4) begin
      phase = dcc_pkg::PHASE_DRYING;
    end else if (time_used < end5) begin
      phase = dcc_pkg::PHASE_COIL_FREEZE;
    end else begin
      // cycle over: start again, emergency goes straight to pump down
      phase = emergency ? dcc_pkg::PHASE_PUMP_DOWN : dcc_pkg::PHASE_WORK;
      emergency_latched_next = 1'b0;
      cycle_minutes_next     = '0;
      emergency_offset_next  = '0;
    end

    low_band = (dcc_pkg::TEMP_W+1)'(set_point) -
               $signed((dcc_pkg::TEMP_W+1)'({1'b0, differential}));
    reached_low_band_next = reached_low_band;
    result_next = '0;
    result_next.phase = phase;
    case (phase)
      dcc_pkg::PHASE_WORK: begin
        result_next.fan_on = 1'b1;
        if ((dcc_pkg::TEMP_W+1)'(in_reg.temperature) > low_band && !reached_low_band) begin
          result_next.pump_on = 1'b1;
        end else begin
          reached_low_band_next = !(in_reg.temperature >= set_point);
        end
      end
      dcc_pkg::PHASE_PUMP_DOWN: begin
        result_next.drain_tray_on = 1'b1;
        result_next.fan_on        = 1'b1;
      end
      dcc_pkg::PHASE_DEFROST: begin
        result_next.drain_tray_on  = 1'b1;
        result_next.coil_heater_on = 1'b1;
      end
      dcc_pkg::PHASE_DRYING: begin
        result_next.drain_tray_on = 1'b1;
      end
      default: begin
        result_next.pump_on       = 1'b1;
        result_next.drain_tray_on = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_minutes     <= '0;
      emergency_offset  <= '0;
      emergency_active  <= 1'b0;
      emergency_latched <= 1'b0;
      reached_low_band  <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (advance) begin
        cycle_minutes     <= cycle_minutes_next;
        emergency_offset  <= emergency_offset_next;
        emergency_active  <= emergency_active_next;
        emergency_latched <= emergency_latched_next;
        reached_low_band  <= reached_low_band_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_data <= result_next;
    end
  end

  // a latched emergency always keeps the active flag
  a_latched_active: assert property (@(posedge clk) disable iff (rst)
    emergency_latched |-> emergency_active)
    else $error("emergency latched without active");

  // work phase never drives drain or coil, and always runs the fan
  a_work_outputs: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.phase == dcc_pkg::PHASE_WORK |->
      !out_data.drain_tray_on && !out_data.coil_heater_on && out_data.fan_on)
    else $error("bad outputs in work phase");

  // an evaluation always leaves a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after evaluation");

  // phase code stays within the five phases
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.phase <= dcc_pkg::PHASE_COIL_FREEZE)
    else $error("phase out of range");

endmodule
